// File: hdl/lru_key_value_cache_assert.svh
// Assertion macros for the LRU key/value cache.
// Included by the top level; no other dependencies.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

`ifndef SYNTHESIS
`define LKVC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LKVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LKVC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define LKVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hdl/lkvc_pkg.sv
// Shared constants and types of the LRU key/value cache.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_BITS_DEF    = 16;
    localparam int VALUE_BITS_DEF  = 32;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register index, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPDATE,
        S_DONE
    } t_state;

endpackage

// File: hdl/lkvc_stream_if.sv
// Request and response stream interfaces of the LRU key/value cache.
// Depends on lkvc_pkg for default payload widths.
`timescale 1ns / 1ps

interface lkvc_req_if #(
    parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, action, key, value, input ready);
    modport sink   (input valid, action, key, value, output ready);
endinterface

interface lkvc_rsp_if #(
    parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;

    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// File: hdl/lkvc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/lru_key_value_cache.sv
// Top level of the LRU key/value cache: control sequencer, entry memory, APB register.
// Depends on lkvc_pkg, lkvc_stream_if, lkvc_ram and lru_key_value_cache_assert.svh.
//
// Usage:
//   i_in carries one word per request: action (0 get, 1 set), key and value.
//   o_out carries one word per request: hit, read_value, evicted, evicted_key.
//   The APB port holds one register, capacity, at byte address 0.
//   Entries live in one memory word each {key, value, rank}; slots 0..fill-1 are
//   in use. A request is taken while the sequencer is idle, even when a previous
//   result still waits in the output register.
//   Steps: the accepted word is scanned against every filled slot, then a
//   decide state picks the target; a get goes on to load its result, while
//   a set first rewrites every filled slot (and the appended slot, if any)
//   in the update pass; with an empty store the scan reads nothing.
//   One pass over the single read port matches the key and finds the least recent
//   entry, and a set runs a second read/modify/write pass to renumber ranks.
//   A stalled receiver holds the result in the output register; the next
//   request is then worked out and waits in the final state until it drains.
//   Reset empties the store (fill count zero) and sets capacity to 16; the
//   entry memory is not cleared and the block is ready right after reset.
`timescale 1ns / 1ps
`include "lru_key_value_cache_assert.svh"

module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = lkvc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = lkvc_pkg::VALUE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    lkvc_req_if.sink                         i_in,
    lkvc_rsp_if.source                       o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lkvc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lkvc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lkvc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    import lkvc_pkg::*;

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int RANK_W = IDX_W;
    localparam int MEM_W  = KEY_BITS + VALUE_BITS + RANK_W;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] val;
        logic [RANK_W-1:0]     rank;
    } t_entry;

    t_state r_state;
    t_state n_state;

    logic [CAP_W-1:0]      r_cap;
    logic [CNT_W-1:0]      r_count;

    logic                  r_set;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;

    logic [CNT_W-1:0]      r_idx;
    logic                  r_rd_vld;
    logic [IDX_W-1:0]      r_rd_idx;

    logic                  r_hit;
    logic [IDX_W-1:0]      r_slot;
    logic [RANK_W-1:0]     r_slot_rank;
    logic [VALUE_BITS-1:0] r_hit_val;
    logic [IDX_W-1:0]      r_vic_slot;
    logic [KEY_BITS-1:0]   r_vic_key;

    logic [IDX_W-1:0]      r_tgt;
    logic                  r_inc_all;
    logic                  r_evict;
    logic [CNT_W-1:0]      r_n_upd;

    logic                  r_o_valid;
    logic                  r_o_hit;
    logic [VALUE_BITS-1:0] r_o_read_value;
    logic                  r_o_evicted;
    logic [KEY_BITS-1:0]   r_o_evicted_key;

    logic                  w_accept;
    logic                  w_rd_en;
    logic                  w_wr_en;
    logic                  w_ld_out;
    logic                  w_cfg_wr;
    logic [MEM_W-1:0]      w_rd_data;
    t_entry                w_rd;
    t_entry                w_wb;
    logic [CMP_W-1:0]      w_cap_ext;
    logic [CMP_W-1:0]      w_max_ext;
    logic [CMP_W-1:0]      w_eff_cap;
    logic                  w_full;

    assign w_rd = w_rd_data;

    // effective capacity: zero acts as one, clamp at depth
    assign w_cap_ext = CMP_W'(r_cap);
    assign w_max_ext = CMP_W'(MAX_ENTRIES);
    always_comb begin
        priority if (r_cap == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (w_cap_ext > w_max_ext) begin
            w_eff_cap = w_max_ext;
        end else begin
            w_eff_cap = w_cap_ext;
        end
    end
    assign w_full = (CMP_W'(r_count) >= w_eff_cap);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_idx == r_count && !r_rd_vld) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_state = r_set ? S_UPDATE : S_DONE;
            end
            S_UPDATE: begin
                if (r_idx == r_n_upd && !r_rd_vld) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || o_out.ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        i_in.ready = 1'b0;
        w_rd_en    = 1'b0;
        w_wr_en    = 1'b0;
        w_ld_out   = 1'b0;
        unique case (r_state)
            S_IDLE:   i_in.ready = 1'b1;
            S_SCAN:   w_rd_en = (r_idx < r_count);
            S_DECIDE: ;
            S_UPDATE: begin
                w_rd_en = (r_idx < r_n_upd);
                w_wr_en = r_rd_vld;
            end
            S_DONE:   w_ld_out = !r_o_valid || o_out.ready;
            default:  ;
        endcase
    end

    assign w_accept = i_in.valid && i_in.ready;

    // write-back word: target takes new entry; newer ones age (all on a miss)
    always_comb begin
        w_wb = w_rd;
        if (r_rd_idx == r_tgt) begin
            w_wb.key  = r_key;
            w_wb.val  = r_val;
            w_wb.rank = '0;
        end else if (r_inc_all || w_rd.rank < r_slot_rank) begin
            w_wb.rank = RANK_W'(w_rd.rank + 1'b1);
        end
    end

    lkvc_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_rd_idx),
        .i_wr_data (w_wb),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= w_rd_en;
            if (r_state == S_DECIDE && r_set && !r_hit && !w_full) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end
            if (w_ld_out) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_set <= i_in.action;
            r_key <= i_in.key;
            r_val <= i_in.value;
            r_idx <= '0;
            r_hit <= 1'b0;
        end
        if (w_rd_en) begin
            r_idx <= CNT_W'(r_idx + 1'b1);
        end
        r_rd_idx <= r_idx[IDX_W-1:0];
        if (r_state == S_SCAN && r_rd_vld) begin
            if (w_rd.key == r_key) begin
                r_hit       <= 1'b1;
                r_slot      <= r_rd_idx;
                r_slot_rank <= w_rd.rank;
                r_hit_val   <= w_rd.val;
            end
            if (CNT_W'(w_rd.rank) == CNT_W'(r_count - 1'b1)) begin
                r_vic_slot <= r_rd_idx;
                r_vic_key  <= w_rd.key;
            end
        end
        if (r_state == S_DECIDE) begin
            r_idx     <= '0;
            r_inc_all <= !r_hit;
            r_evict   <= r_set && !r_hit && w_full;
            priority if (r_hit) begin
                r_tgt   <= r_slot;
                r_n_upd <= r_count;
            end else if (w_full) begin
                r_tgt   <= r_vic_slot;
                r_n_upd <= r_count;
            end else begin
                r_tgt   <= r_count[IDX_W-1:0];
                r_n_upd <= CNT_W'(r_count + 1'b1);
            end
        end
        if (w_ld_out) begin
            r_o_hit         <= r_hit;
            r_o_read_value  <= (!r_set && r_hit) ? r_hit_val : '0;
            r_o_evicted     <= r_evict;
            r_o_evicted_key <= r_evict ? r_vic_key : '0;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.hit         = r_o_hit;
    assign o_out.read_value  = r_o_read_value;
    assign o_out.evicted     = r_o_evicted;
    assign o_out.evicted_key = r_o_evicted_key;

    // APB register
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata   = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(r_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (w_cfg_wr) begin
            r_cap <= pwdata[CAP_W-1:0];
        end
    end

    `LKVC_ASSERT_IMPL(a_count_max, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(MAX_ENTRIES), "fill count above depth")
    `LKVC_ASSERT_NEXT(a_accept_scan, i_clk, i_rst_n, i_in.valid && i_in.ready,
        r_state == S_SCAN, "accepted word did not start a scan")
    `LKVC_ASSERT_NEXT(a_load_out, i_clk, i_rst_n,
        r_state == S_DONE && (!o_out.valid || o_out.ready),
        o_out.valid && r_state == S_IDLE, "result not loaded")
    `LKVC_ASSERT_IMPL(a_wb_range, i_clk, i_rst_n, r_state == S_UPDATE && r_rd_vld,
        CNT_W'(r_rd_idx) < r_n_upd, "write-back outside pass")

endmodule
